// ----- sv/cdq_pkg.sv -----
package cdq_pkg;

    localparam int REQ_W  = 3;
    localparam int WORD_W = 32;
    localparam int CFG_W  = 11;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    // reported for both ends while the deque is empty
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    localparam int CFG_CAP_RST = 1024;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RD   = 2'b10
    } t_state;

endpackage

// ----- sv/cdq_ifs.sv -----
interface cdq_req_if
    import cdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_rsp_if
    import cdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     is_empty;
    logic                     is_full;

    modport source (
        output valid, output accepted, output front_word, output rear_word,
        output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input accepted, input front_word, input rear_word,
        input is_empty, input is_full, output ready
    );
endinterface

// ----- sv/cdq_ram.sv -----
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/circular_deque_buffer.sv -----
// Double-ended queue of signed 32-bit words kept in a ring RAM of STORE_DEPTH
// entries; the capacity register (reset 1024 or STORE_DEPTH if less, 0 acts
// as 1, values above STORE_DEPTH act as STORE_DEPTH) limits how many are used,
// and writing it empties the deque at once with no clearing pass. The words at
// both ends are also held in registers, so pushes, queries, refused requests
// and pops that empty the deque need no RAM read and may follow each other in
// every cycle while results are taken, each result registered in the cycle
// after its item is taken. A pop that leaves entries behind passes through
// ST_RD, where the new end word from the ring RAM's registered read port is
// loaded into the result register. One item is in the block at a time; the
// next is taken in the cycle the previous result leaves the output register.
module circular_deque_buffer
    import cdq_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    cdq_req_if.sink          i_req,
    cdq_rsp_if.source        o_rsp
);

    localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNTW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH + 1) : 1;
    localparam int PW   = AW + 1;
    localparam int XW   = (CNTW > CFG_W) ? CNTW : CFG_W;
    localparam int CAP_RST = (STORE_DEPTH < CFG_CAP_RST) ? STORE_DEPTH : CFG_CAP_RST;

    t_state                   r_state;
    logic [CNTW-1:0]          r_cap;
    logic [AW-1:0]            r_head;
    logic [AW-1:0]            r_tail;
    logic [CNTW-1:0]          r_count;
    logic signed [WORD_W-1:0] r_front;
    logic signed [WORD_W-1:0] r_rear;
    logic                     r_rd_front;

    logic                     r_out_valid;
    logic                     r_out_ok;
    logic signed [WORD_W-1:0] r_out_front;
    logic signed [WORD_W-1:0] r_out_rear;
    logic                     r_out_empty;
    logic                     r_out_full;

    logic [AW-1:0]            n_head;
    logic [AW-1:0]            n_tail;
    logic [CNTW-1:0]          n_count;
    logic signed [WORD_W-1:0] n_front;
    logic signed [WORD_W-1:0] n_rear;
    logic                     n_out_valid;

    logic                     in_fire;
    logic                     out_free;
    logic                     cur_empty;
    logic                     cur_full;
    logic                     ok;
    logic                     wr;
    logic                     need_rd;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [WORD_W-1:0]        ram_rdata;
    logic [PW-1:0]            cap_p;
    logic [PW-1:0]            head_p1;
    logic [PW-1:0]            tail_p1;
    logic [AW-1:0]            cap_m1;
    logic [AW-1:0]            head_inc;
    logic [AW-1:0]            head_dec;
    logic [AW-1:0]            tail_inc;
    logic [AW-1:0]            tail_dec;
    logic [XW-1:0]            cfg_x;
    logic [CNTW-1:0]          cfg_cap;
    logic                     nx_empty;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign in_fire   = i_req.valid && i_req.ready;
    assign cur_empty = (r_count == '0);
    assign cur_full  = (r_count >= r_cap);

    // wrap by compare against the effective capacity
    assign cap_p    = PW'(r_cap);
    assign cap_m1   = AW'(r_cap - CNTW'(1));
    assign head_p1  = PW'(r_head) + PW'(1);
    assign tail_p1  = PW'(r_tail) + PW'(1);
    assign head_inc = (head_p1 >= cap_p) ? '0 : head_p1[AW-1:0];
    assign tail_inc = (tail_p1 >= cap_p) ? '0 : tail_p1[AW-1:0];
    assign head_dec = (r_head == '0) ? cap_m1 : r_head - AW'(1);
    assign tail_dec = (r_tail == '0) ? cap_m1 : r_tail - AW'(1);

    assign cfg_x   = XW'(i_cfg_wdata);
    assign cfg_cap = (cfg_x == '0) ? CNTW'(1) :
                     (cfg_x > XW'(STORE_DEPTH)) ? CNTW'(STORE_DEPTH) : CNTW'(cfg_x);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_front   = r_front;
        n_rear    = r_rear;
        ok        = 1'b0;
        wr        = 1'b0;
        need_rd   = 1'b0;
        ram_waddr = r_head;
        ram_raddr = r_head;
        case (i_req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (!cur_full) begin
                    ok      = 1'b1;
                    wr      = 1'b1;
                    n_count = r_count + CNTW'(1);
                    if (cur_empty) begin
                        // first item sits at the head, both ends point at it
                        n_tail  = r_head;
                        n_front = i_req.push_value;
                        n_rear  = i_req.push_value;
                    end else if (i_req.req_type == REQ_PUSH_FRONT) begin
                        n_head    = head_dec;
                        ram_waddr = head_dec;
                        n_front   = i_req.push_value;
                    end else begin
                        n_tail    = tail_inc;
                        ram_waddr = tail_inc;
                        n_rear    = i_req.push_value;
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (!cur_empty) begin
                    ok = 1'b1;
                    if (r_count == CNTW'(1)) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end else begin
                        n_count = r_count - CNTW'(1);
                        need_rd = 1'b1;
                        if (i_req.req_type == REQ_POP_FRONT) begin
                            n_head    = head_inc;
                            ram_raddr = head_inc;
                        end else begin
                            n_tail    = tail_dec;
                            ram_raddr = tail_dec;
                        end
                    end
                end
            end
            REQ_QUERY: begin
                ok = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign ram_we   = in_fire && wr;
    assign nx_empty = (n_count == '0);

    // result register fills from an item needing no RAM read or from a finished read, empties when taken
    assign n_out_valid = (r_state == ST_RD) || (in_fire && !need_rd) ||
                         (r_out_valid && !o_rsp.ready);

    // writes only in the accept cycle, reads land in ST_RD when nothing is taken
    cdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.push_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CNTW'(CAP_RST);
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap   <= cfg_cap;
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (in_fire) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && need_rd) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            if (r_rd_front) begin
                r_front     <= ram_rdata;
                r_out_front <= ram_rdata;
                r_out_rear  <= r_rear;
            end else begin
                r_rear      <= ram_rdata;
                r_out_front <= r_front;
                r_out_rear  <= ram_rdata;
            end
            r_out_ok    <= 1'b1;
            r_out_empty <= 1'b0;
            r_out_full  <= (r_count >= r_cap);
        end else if (in_fire) begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_rd_front  <= (i_req.req_type == REQ_POP_FRONT);
            r_out_ok    <= ok;
            r_out_front <= nx_empty ? EMPTY_WORD : n_front;
            r_out_rear  <= nx_empty ? EMPTY_WORD : n_rear;
            r_out_empty <= nx_empty;
            r_out_full  <= (n_count >= r_cap);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.accepted   = r_out_ok;
    assign o_rsp.front_word = r_out_front;
    assign o_rsp.rear_word  = r_out_rear;
    assign o_rsp.is_empty   = r_out_empty;
    assign o_rsp.is_full    = r_out_full;

endmodule

// ----- sv/cdq_chk.sv -----
module cdq_chk
    import cdq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_req_valid,
    input logic                     i_req_ready,
    input logic                     i_rsp_valid,
    input logic                     i_rsp_ready,
    input logic                     i_rsp_accepted,
    input logic signed [WORD_W-1:0] i_rsp_front_word,
    input logic signed [WORD_W-1:0] i_rsp_rear_word,
    input logic                     i_rsp_is_empty,
    input logic                     i_rsp_is_full
);

    logic r_inflight;
    logic in_fire;
    logic out_fire;

    assign in_fire  = i_req_valid && i_req_ready;
    assign out_fire = i_rsp_valid && i_rsp_ready;

    // an item has been taken and its result not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
        end else if (in_fire) begin
            r_inflight <= 1'b1;
        end else if (out_fire) begin
            r_inflight <= 1'b0;
        end
    end

    a_rsp_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_inflight)
        else $error("result shown with no item outstanding");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_inflight || out_fire))
        else $error("item taken while an earlier result is still owed");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_is_empty) |->
            (i_rsp_front_word == EMPTY_WORD && i_rsp_rear_word == EMPTY_WORD
             && !i_rsp_is_full))
        else $error("empty deque reports words or full");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_accepted) && $stable(i_rsp_front_word)
             && $stable(i_rsp_rear_word) && $stable(i_rsp_is_empty)
             && $stable(i_rsp_is_full)))
        else $error("stalled result changed");

endmodule

bind circular_deque_buffer cdq_chk u_cdq_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_accepted   (o_rsp.accepted),
    .i_rsp_front_word (o_rsp.front_word),
    .i_rsp_rear_word  (o_rsp.rear_word),
    .i_rsp_is_empty   (o_rsp.is_empty),
    .i_rsp_is_full    (o_rsp.is_full)
);
